// ===== rtl/core/rpnfse_pkg.sv =====
package rpnfse_pkg;

	localparam int unsigned STACK_DEPTH_DEF = 16;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_OVERFLOW = 3'd1;
	localparam logic [2:0] ST_UNDERFLOW = 3'd2;
	localparam logic [2:0] ST_INVALID  = 3'd3;
	localparam logic [2:0] ST_ZERODIV  = 3'd4;
	localparam logic [2:0] ST_LEFTOVER = 3'd5;

	typedef struct packed {
		logic [7:0] symbol;
		logic       is_last;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		logic [2:0]         status;
	} out_word_t;

	typedef enum logic [2:0] {
		OP_PUSH,
		OP_NOP,
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV,
		OP_BAD
	} op_t;

	// classified word handed from front to back
	typedef struct packed {
		op_t        op;
		logic [3:0] digit;
		logic       is_last;
	} cmd_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_RD0,
		B_RD1,
		B_MUL0,
		B_MUL1,
		B_COMB,
		B_FRD,
		B_FIN,
		B_DIV,
		B_DIVEND,
		B_OUT
	} bstate_t;

endpackage

// ===== rtl/core/rpn_fraction_stack_evaluator_top.sv =====
// channel | dir | handshake            | payload
// in      | in  | in_valid / in_ready  | in_data  (symbol, is_last)
// out     | out | out_valid / out_ready | out_data (result_value, status)
//
// digit, space or error-skipped word: handled in the back end's idle state
// operator: two stack ram reads, two multiply stages, combine
// last word: adds top-of-stack read, status and result states, plus the serial divider
// when the quotient is computed; a stalled result holds the back end
// a two-entry queue lets the front keep accepting while the back end works
// arst_n clears stack pointer, error latch and queue; stack ram is not cleared
module rpn_fraction_stack_evaluator_top #(
	parameter int unsigned STACK_DEPTH = rpnfse_pkg::STACK_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  rpnfse_pkg::in_word_t  in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output rpnfse_pkg::out_word_t out_data
);

	logic             cmd_valid, cmd_ready;
	rpnfse_pkg::cmd_t cmd;

	// front: classify and queue words
	rpnfse_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd));

	// back: stack, arithmetic, final divide
	rpnfse_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data));

`ifndef ASSERT_OFF
	// a result with an error code carries a zero value
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != rpnfse_pkg::ST_OK |-> out_data.result_value == 32'sd0)
		else $error("error result with nonzero value");
	// status stays within defined codes
	a_stat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.status <= rpnfse_pkg::ST_LEFTOVER)
		else $error("bad status code");
	// a pending result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result dropped");
`endif

endmodule

// ===== rtl/core/rpnfse_ram.sv =====
module rpnfse_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/rpnfse_front.sv =====
module rpnfse_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  rpnfse_pkg::in_word_t in_data,
	output logic                 cmd_valid,
	input  logic                 cmd_ready,
	output rpnfse_pkg::cmd_t     cmd
);

	rpnfse_pkg::cmd_t q_q [rpnfse_pkg::QUEUE_DEPTH];
	logic             rp_q, wp_q;
	logic [1:0]       cnt_q;
	rpnfse_pkg::cmd_t cls;

	always_comb begin
		cls.digit = in_data.symbol[3:0];
		cls.is_last = in_data.is_last;
		if (in_data.symbol >= rpnfse_pkg::CH_ZERO && in_data.symbol <= rpnfse_pkg::CH_NINE)
			cls.op = rpnfse_pkg::OP_PUSH;
		else if (in_data.symbol == rpnfse_pkg::CH_SPACE)
			cls.op = rpnfse_pkg::OP_NOP;
		else if (in_data.symbol == rpnfse_pkg::CH_PLUS)
			cls.op = rpnfse_pkg::OP_ADD;
		else if (in_data.symbol == rpnfse_pkg::CH_MINUS)
			cls.op = rpnfse_pkg::OP_SUB;
		else if (in_data.symbol == rpnfse_pkg::CH_STAR)
			cls.op = rpnfse_pkg::OP_MUL;
		else if (in_data.symbol == rpnfse_pkg::CH_SLASH)
			cls.op = rpnfse_pkg::OP_DIV;
		else
			cls.op = rpnfse_pkg::OP_BAD;
	end

	assign in_ready  = (cnt_q != 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = q_q[rp_q];

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			q_q[wp_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q <= 1'b0;
			wp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (in_valid && in_ready)
				wp_q <= ~wp_q;
			if (cmd_valid && cmd_ready)
				rp_q <= ~rp_q;
			case ({in_valid && in_ready, cmd_valid && cmd_ready})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== rtl/core/rpnfse_back.sv =====
module rpnfse_back #(
	parameter int unsigned STACK_DEPTH = rpnfse_pkg::STACK_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_ready,
	input  rpnfse_pkg::cmd_t      cmd,
	output logic                  out_valid,
	input  logic                  out_ready,
	output rpnfse_pkg::out_word_t out_data
);

	localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int unsigned PW = $clog2(STACK_DEPTH + 1);
	localparam logic [PW-1:0] FULL = PW'(STACK_DEPTH);

	rpnfse_pkg::bstate_t state_q, state_d;
	rpnfse_pkg::cmd_t    cmd_q;
	logic [PW-1:0]       sp_q;
	logic [2:0]          err_q;
	logic [31:0]         bn_q, bd_q, an_q, ad_q;
	logic [31:0]         p0_q, p1_q, p2_q;
	logic [31:0]         res_q;
	logic [2:0]          stat_q;

	// iterative divider for the final quotient
	logic [31:0] dq_q, dr_q, dd_q;
	logic [5:0]  dcnt_q;
	logic        dneg_q;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [31:0]   wn, wd, rn, rd;

	rpnfse_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_num (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wn), .raddr(raddr), .rdata(rn));
	rpnfse_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_den (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wd), .raddr(raddr), .rdata(rd));

	logic [PW-1:0] rsel;
	logic          is_op;
	logic [31:0]   rn_c, rd_c;
	logic          push_full;

	assign is_op = (cmd_q.op == rpnfse_pkg::OP_ADD) || (cmd_q.op == rpnfse_pkg::OP_SUB) ||
		(cmd_q.op == rpnfse_pkg::OP_MUL) || (cmd_q.op == rpnfse_pkg::OP_DIV);
	assign push_full = (sp_q >= FULL);

	always_comb begin
		rsel = sp_q - PW'(1);
		if (state_q == rpnfse_pkg::B_RD0)
			rsel = sp_q - PW'(2);
		raddr = rsel[AW-1:0];
	end

	always_comb begin
		case (cmd_q.op)
			rpnfse_pkg::OP_ADD: rn_c = p0_q + p1_q;
			rpnfse_pkg::OP_SUB: rn_c = p0_q - p1_q;
			rpnfse_pkg::OP_MUL: rn_c = p1_q;
			default: rn_c = p0_q;
		endcase
		rd_c = p2_q;
	end

	// stack write
	always_comb begin
		we = 1'b0;
		waddr = sp_q[AW-1:0];
		wn = rn_c;
		wd = rd_c;
		if (state_q == rpnfse_pkg::B_IDLE && cmd_valid && err_q == rpnfse_pkg::ST_OK &&
				cmd.op == rpnfse_pkg::OP_PUSH && !push_full) begin
			we = 1'b1;
			wn = {28'd0, cmd.digit};
			wd = 32'd1;
		end else if (state_q == rpnfse_pkg::B_COMB && !push_full &&
				!(cmd_q.op == rpnfse_pkg::OP_DIV && rd_c == 32'd0)) begin
			we = 1'b1;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			rpnfse_pkg::B_IDLE: begin
				if (cmd_valid) begin
					if (err_q != rpnfse_pkg::ST_OK || cmd.op == rpnfse_pkg::OP_PUSH ||
							cmd.op == rpnfse_pkg::OP_NOP || sp_q < PW'(2))
						state_d = cmd.is_last ? rpnfse_pkg::B_FRD : rpnfse_pkg::B_IDLE;
					else
						state_d = rpnfse_pkg::B_RD0;
				end
			end
			rpnfse_pkg::B_RD0:  state_d = rpnfse_pkg::B_RD1;
			rpnfse_pkg::B_RD1:  state_d = is_op ? rpnfse_pkg::B_MUL0 :
				(cmd_q.is_last ? rpnfse_pkg::B_FRD : rpnfse_pkg::B_IDLE);
			rpnfse_pkg::B_MUL0: state_d = rpnfse_pkg::B_MUL1;
			rpnfse_pkg::B_MUL1: state_d = rpnfse_pkg::B_COMB;
			rpnfse_pkg::B_COMB: state_d = cmd_q.is_last ? rpnfse_pkg::B_FRD : rpnfse_pkg::B_IDLE;
			rpnfse_pkg::B_FRD:  state_d = rpnfse_pkg::B_FIN;
			rpnfse_pkg::B_FIN: begin
				if (err_q != rpnfse_pkg::ST_OK || sp_q != PW'(1) || rd == 32'd0)
					state_d = rpnfse_pkg::B_OUT;
				else
					state_d = rpnfse_pkg::B_DIV;
			end
			rpnfse_pkg::B_DIV:    state_d = (dcnt_q == 6'd0) ? rpnfse_pkg::B_DIVEND : rpnfse_pkg::B_DIV;
			rpnfse_pkg::B_DIVEND: state_d = rpnfse_pkg::B_OUT;
			rpnfse_pkg::B_OUT:    state_d = out_ready ? rpnfse_pkg::B_IDLE : rpnfse_pkg::B_OUT;
			default: state_d = rpnfse_pkg::B_IDLE;
		endcase
	end

	always_comb begin
		cmd_ready = (state_q == rpnfse_pkg::B_IDLE);
		out_valid = (state_q == rpnfse_pkg::B_OUT);
		out_data.result_value = res_q;
		out_data.status = stat_q;
	end

	logic [32:0] dtrial;
	assign dtrial = {dr_q, dq_q[31]} - {1'b0, dd_q};

	always_ff @(posedge clk) begin
		case (state_q)
			rpnfse_pkg::B_IDLE: if (cmd_valid) cmd_q <= cmd;
			rpnfse_pkg::B_RD0:  begin bn_q <= rn; bd_q <= rd; end
			rpnfse_pkg::B_RD1:  begin an_q <= rn; ad_q <= rd; end
			rpnfse_pkg::B_MUL0: begin
				p0_q <= an_q * bd_q;
				p2_q <= ad_q * bd_q;
			end
			rpnfse_pkg::B_MUL1: begin
				p1_q <= (cmd_q.op == rpnfse_pkg::OP_MUL) ? an_q * bn_q : bn_q * ad_q;
				if (cmd_q.op == rpnfse_pkg::OP_DIV)
					p2_q <= ad_q * bn_q;
			end
			rpnfse_pkg::B_FIN: begin
				dq_q <= rn[31] ? 32'd0 - rn : rn;
				dd_q <= rd[31] ? 32'd0 - rd : rd;
				dr_q <= 32'd0;
				dneg_q <= rn[31] ^ rd[31];
				dcnt_q <= 6'd31;
			end
			rpnfse_pkg::B_DIV: begin
				if (!dtrial[32]) dr_q <= dtrial[31:0];
				else dr_q <= {dr_q[30:0], dq_q[31]};
				dq_q <= {dq_q[30:0], ~dtrial[32]};
				dcnt_q <= dcnt_q - 6'd1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rpnfse_pkg::B_IDLE;
			sp_q <= '0;
			err_q <= rpnfse_pkg::ST_OK;
			res_q <= '0;
			stat_q <= rpnfse_pkg::ST_OK;
		end else begin
			state_q <= state_d;
			case (state_q)
				rpnfse_pkg::B_IDLE: begin
					if (cmd_valid && err_q == rpnfse_pkg::ST_OK) begin
						if (cmd.op == rpnfse_pkg::OP_PUSH) begin
							if (push_full) err_q <= rpnfse_pkg::ST_OVERFLOW;
							else sp_q <= sp_q + PW'(1);
						end else if (cmd.op != rpnfse_pkg::OP_NOP && sp_q < PW'(2)) begin
							err_q <= rpnfse_pkg::ST_UNDERFLOW;
						end
					end
				end
				rpnfse_pkg::B_RD1: begin
					sp_q <= sp_q - PW'(2);
					if (!is_op) err_q <= rpnfse_pkg::ST_INVALID;
				end
				rpnfse_pkg::B_COMB: begin
					if (cmd_q.op == rpnfse_pkg::OP_DIV && rd_c == 32'd0)
						err_q <= rpnfse_pkg::ST_ZERODIV;
					else if (push_full) err_q <= rpnfse_pkg::ST_OVERFLOW;
					else sp_q <= sp_q + PW'(1);
				end
				rpnfse_pkg::B_FIN: begin
					res_q <= '0;
					if (err_q != rpnfse_pkg::ST_OK) stat_q <= err_q;
					else if (sp_q == '0) stat_q <= rpnfse_pkg::ST_UNDERFLOW;
					else if (sp_q != PW'(1)) stat_q <= rpnfse_pkg::ST_LEFTOVER;
					else if (rd == 32'd0) stat_q <= rpnfse_pkg::ST_ZERODIV;
					else stat_q <= rpnfse_pkg::ST_OK;
					sp_q <= '0;
					err_q <= rpnfse_pkg::ST_OK;
				end
				rpnfse_pkg::B_DIVEND: res_q <= dneg_q ? 32'd0 - dq_q : dq_q;
				default: ;
			endcase
		end
	end

endmodule
